FILE: rtl/triangle_cell_density_averager_core_assert.svh
// ----------------------------------------------------------------------------
// Triangle cell density averager assertion macros
// Short forms for the clocked, reset-qualified checks used by the checker.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_CELL_DENSITY_AVERAGER_CORE_ASSERT_SVH
`define TRIANGLE_CELL_DENSITY_AVERAGER_CORE_ASSERT_SVH

// Check the consequent in the cycle after the antecedent
`define TCDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check the consequent in the same cycle as the antecedent
`define TCDA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tcda_pkg.sv
// ----------------------------------------------------------------------------
// Triangle cell density averager package
// Shared widths, defaults and the transaction types between front and back.
// ----------------------------------------------------------------------------
package tcda_pkg;

    localparam int PIX_W      = 8;
    localparam int STRIDE_W   = 5;
    localparam int DIM_W      = 11;
    localparam int POS_W      = 9;
    localparam int DENS_W     = 16;
    localparam int COL_W      = 12;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam int DEF_MAX_STRIDE    = 16;
    localparam int DEF_MAX_WIDTH     = 1024;
    localparam int DEF_MAX_HEIGHT    = 1024;
    localparam int DEF_MAX_CELL_COLS = 512;

    typedef enum logic [1:0] {
        CLS_DIAG,
        CLS_TRI0,
        CLS_TRI1
    } tri_class_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [POS_W-1:0] row;
        logic [PIX_W-1:0] pix;
        tri_class_t       cls;
        logic             first;
        logic             last;
        logic             lof;
    } cell_item_t;

    typedef struct packed {
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [DENS_W-1:0] upper;
        logic [DENS_W-1:0] lower;
        logic              lof;
    } cell_result_t;

endpackage

FILE: rtl/tcda_fifo.sv
// ----------------------------------------------------------------------------
// Small synchronous FIFO
// Registered storage with a fill count; decouples two handshake sides.
// ----------------------------------------------------------------------------
module tcda_fifo
    import tcda_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: rtl/tcda_front.sv
// ----------------------------------------------------------------------------
// Triangle cell density averager front end
// Track raster position, split it into cell and in-cell offsets, classify.
// ----------------------------------------------------------------------------
module tcda_front
    import tcda_pkg::*;
#(
    parameter int MAX_CELL_COLS = DEF_MAX_CELL_COLS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [STRIDE_W-1:0] cfg_stride,
    input  logic [DIM_W-1:0]    cfg_width,
    input  logic [DIM_W-1:0]    cfg_height,
    input  logic                clearing,
    input  logic                push,
    output logic                full,
    input  logic [PIX_W-1:0]    pixel_value,
    input  logic                frame_start,
    output cell_item_t          item_out,
    output logic                item_push,
    input  logic                item_full
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_CLS  = 2'd2;
    localparam int         CNT_W  = $clog2(DIM_W);
    localparam int         CC_W   = COL_W + 1;

    logic [1:0]          state_reg, state_next;
    logic [DIM_W-1:0]    pos_x_reg, pos_x_next;
    logic [DIM_W-1:0]    pos_y_reg, pos_y_next;
    logic [PIX_W-1:0]    pix_reg, pix_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DIM_W-1:0]    qx_reg, qx_next, qy_reg, qy_next;
    logic [DIM_W-1:0]    qw_reg, qw_next, qh_reg, qh_next;
    logic [STRIDE_W-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic [STRIDE_W-1:0] rw_reg, rw_next, rh_reg, rh_next;

    logic [DIM_W-1:0]    x0, y0, y1, nx, ny;
    logic                accept;
    logic [CC_W-1:0]     cols;
    logic                in_grid;
    logic                odd;
    logic [STRIDE_W-1:0] dpos;
    logic [STRIDE_W-1:0] s_m1;

    function automatic logic [STRIDE_W+DIM_W-1:0] div_step(
        input logic [STRIDE_W-1:0] r,
        input logic [DIM_W-1:0]    q,
        input logic [STRIDE_W-1:0] d
    );
        logic [STRIDE_W:0] t;
        logic              b;
        t = {r, q[DIM_W-1]};
        b = (t >= {1'b0, d});
        if (b)
        begin
            t = t - {1'b0, d};
        end
        return {t[STRIDE_W-1:0], q[DIM_W-2:0], b};
    endfunction

    assign full   = (state_reg != F_IDLE) || clearing;
    assign accept = push && !full;
    assign s_m1   = cfg_stride - 1'b1;

    // Position of this pixel and of the next one
    always_comb
    begin
        x0 = frame_start ? '0 : pos_x_reg;
        y0 = frame_start ? '0 : pos_y_reg;
        y1 = y0;
        if (x0 >= cfg_width)
        begin
            x0 = '0;
            y1 = y0 + 1'b1;
        end
        if (y1 >= cfg_height)
        begin
            y1 = '0;
        end
        nx = x0 + 1'b1;
        ny = y1;
        if (nx >= cfg_width)
        begin
            nx = '0;
            ny = y1 + 1'b1;
            if (ny >= cfg_height)
            begin
                ny = '0;
            end
        end
    end

    // Classification from quotients and remainders
    always_comb
    begin
        cols = ({2'b0, qw_reg} > CC_W'(MAX_CELL_COLS)) ? CC_W'(MAX_CELL_COLS)
                                                       : {2'b0, qw_reg};
        in_grid = ({2'b0, qx_reg} < cols) && (qy_reg < qh_reg);
        odd     = qx_reg[0] ^ qy_reg[0];
        dpos    = odd ? (s_m1 - ry_reg) : ry_reg;
        item_out.col   = COL_W'(qx_reg);
        item_out.row   = qy_reg[POS_W-1:0];
        item_out.pix   = pix_reg;
        item_out.first = (rx_reg == '0) && (ry_reg == '0);
        item_out.last  = (rx_reg == s_m1) && (ry_reg == s_m1);
        item_out.lof   = (qy_reg == qh_reg - 1'b1) && (cols == {2'b0, qx_reg} + 1'b1);
        if (rx_reg == dpos)
        begin
            item_out.cls = CLS_DIAG;
        end
        else if (odd ? (rx_reg < dpos) : (rx_reg > dpos))
        begin
            item_out.cls = CLS_TRI0;
        end
        else
        begin
            item_out.cls = CLS_TRI1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pix_next   = pix_reg;
        cnt_next   = cnt_reg;
        qx_next    = qx_reg;
        qy_next    = qy_reg;
        qw_next    = qw_reg;
        qh_next    = qh_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        rw_next    = rw_reg;
        rh_next    = rh_reg;
        item_push  = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    pos_x_next = nx;
                    pos_y_next = ny;
                    pix_next   = pixel_value;
                    qx_next    = x0;
                    qy_next    = y1;
                    qw_next    = cfg_width;
                    qh_next    = cfg_height;
                    rx_next    = '0;
                    ry_next    = '0;
                    rw_next    = '0;
                    rh_next    = '0;
                    cnt_next   = '0;
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                // one quotient bit per lane per cycle
                {rx_next, qx_next} = div_step(rx_reg, qx_reg, cfg_stride);
                {ry_next, qy_next} = div_step(ry_reg, qy_reg, cfg_stride);
                {rw_next, qw_next} = div_step(rw_reg, qw_reg, cfg_stride);
                {rh_next, qh_next} = div_step(rh_reg, qh_reg, cfg_stride);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIM_W - 1))
                begin
                    state_next = F_CLS;
                end
            end
            F_CLS:
            begin
                if (!in_grid)
                begin
                    state_next = F_IDLE;
                end
                else if (!item_full)
                begin
                    item_push  = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
        qx_reg  <= qx_next;
        qy_reg  <= qy_next;
        qw_reg  <= qw_next;
        qh_reg  <= qh_next;
        rx_reg  <= rx_next;
        ry_reg  <= ry_next;
        rw_reg  <= rw_next;
        rh_reg  <= rh_next;
    end

endmodule

FILE: rtl/tcda_back.sv
// ----------------------------------------------------------------------------
// Triangle cell density averager back end
// Accumulate per-column sums in memory and divide out densities per cell.
// ----------------------------------------------------------------------------
module tcda_back
    import tcda_pkg::*;
#(
    parameter int MAX_STRIDE    = DEF_MAX_STRIDE,
    parameter int MAX_CELL_COLS = DEF_MAX_CELL_COLS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [STRIDE_W-1:0] cfg_stride,
    input  logic                cfg_box,
    output logic                clearing,
    input  cell_item_t          item_in,
    input  logic                item_empty,
    output logic                item_pop,
    output cell_result_t        res_out,
    output logic                res_push,
    input  logic                res_full
);

    localparam int CAW   = $clog2(MAX_CELL_COLS);
    localparam int TS_W  = $clog2(MAX_STRIDE * MAX_STRIDE * 255 + 1);
    localparam int DG_W  = $clog2(MAX_STRIDE * 255 + 1);
    localparam int NW    = TS_W + 1;
    localparam int DEN_W = $clog2(MAX_STRIDE * MAX_STRIDE + 1);
    localparam int FW    = DEN_W + 8;
    localparam int XW    = ((NW > FW) ? NW : FW) + 1;
    localparam int RW    = FW + 2;
    localparam int MW    = 2 * TS_W + DG_W;
    localparam int DC_W  = $clog2(DENS_W);

    localparam logic [2:0] B_CLR  = 3'd0;
    localparam logic [2:0] B_IDLE = 3'd1;
    localparam logic [2:0] B_UPD  = 3'd2;
    localparam logic [2:0] B_NUM  = 3'd3;
    localparam logic [2:0] B_FULL = 3'd4;
    localparam logic [2:0] B_DIV  = 3'd5;
    localparam logic [2:0] B_OUT  = 3'd6;

    logic [MW-1:0]     sum_mem [MAX_CELL_COLS];
    logic [MW-1:0]     rd_data_reg;

    logic [2:0]        state_reg, state_next;
    logic [CAW-1:0]    clr_addr_reg, clr_addr_next;
    cell_item_t        item_reg, item_next;
    logic [TS_W-1:0]   t0_reg, t0_next, t1_reg, t1_next;
    logic [DG_W-1:0]   dg_reg, dg_next;
    logic [NW-1:0]     num0_reg, num0_next, num1_reg, num1_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [FW:0]       d2_reg, d2_next;
    logic [DENS_W-1:0] lo_reg, lo_next;
    logic [RW-1:0]     rem0_reg, rem0_next, rem1_reg, rem1_next;
    logic [DENS_W-1:0] q0_reg, q0_next, q1_reg, q1_next;
    logic [DC_W-1:0]   cnt_reg, cnt_next;

    logic              mem_we;
    logic [CAW-1:0]    mem_waddr;
    logic [MW-1:0]     mem_wdata;
    logic              mem_re;

    logic [TS_W-1:0]   base_t0, base_t1;
    logic [DG_W-1:0]   base_dg;
    logic [2*STRIDE_W-1:0] s_sq;
    logic [FW-1:0]     full_v;
    logic [XW-1:0]     full_x;
    logic [XW-1:0]     diff0_x, diff1_x;
    logic [RW-1:0]     r2_0, r2_1;

    assign clearing = (state_reg == B_CLR);
    assign s_sq     = cfg_stride * cfg_stride;
    assign full_v   = (FW'(den_reg) << 8) - FW'(den_reg);
    assign full_x   = XW'(full_v);
    assign diff0_x  = (XW'(num0_reg) < full_x) ? (full_x - XW'(num0_reg)) : '0;
    assign diff1_x  = (XW'(num1_reg) < full_x) ? (full_x - XW'(num1_reg)) : '0;
    assign r2_0     = {rem0_reg[RW-2:0], lo_reg[DENS_W-1]};
    assign r2_1     = {rem1_reg[RW-2:0], lo_reg[DENS_W-1]};

    assign res_out.row   = item_reg.row;
    assign res_out.col   = item_reg.col[POS_W-1:0];
    assign res_out.upper = q0_reg;
    assign res_out.lower = q1_reg;
    assign res_out.lof   = item_reg.lof;

    always_comb
    begin
        {base_t0, base_t1, base_dg} = item_reg.first ? '0 : rd_data_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        item_next     = item_reg;
        t0_next       = t0_reg;
        t1_next       = t1_reg;
        dg_next       = dg_reg;
        num0_next     = num0_reg;
        num1_next     = num1_reg;
        den_next      = den_reg;
        d2_next       = d2_reg;
        lo_next       = lo_reg;
        rem0_next     = rem0_reg;
        rem1_next     = rem1_reg;
        q0_next       = q0_reg;
        q1_next       = q1_reg;
        cnt_next      = cnt_reg;
        item_pop      = 1'b0;
        res_push      = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = item_reg.col[CAW-1:0];
        mem_wdata     = '0;
        mem_re        = 1'b0;
        unique case (state_reg)
            B_CLR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == CAW'(MAX_CELL_COLS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!item_empty)
                begin
                    item_pop   = 1'b1;
                    mem_re     = 1'b1;
                    item_next  = item_in;
                    state_next = B_UPD;
                end
            end
            B_UPD:
            begin
                t0_next = base_t0;
                t1_next = base_t1;
                dg_next = base_dg;
                case (item_reg.cls)
                    CLS_DIAG: dg_next = base_dg + DG_W'(item_reg.pix);
                    CLS_TRI0: t0_next = base_t0 + TS_W'(item_reg.pix);
                    CLS_TRI1: t1_next = base_t1 + TS_W'(item_reg.pix);
                    default:  dg_next = base_dg;
                endcase
                mem_we     = 1'b1;
                mem_wdata  = {t0_next, t1_next, dg_next};
                state_next = item_reg.last ? B_NUM : B_IDLE;
            end
            B_NUM:
            begin
                if (cfg_box)
                begin
                    num0_next = NW'(t0_reg) + NW'(t1_reg) + NW'(dg_reg);
                    num1_next = num0_next;
                    den_next  = DEN_W'(s_sq);
                end
                else
                begin
                    num0_next = {t0_reg, 1'b0} + NW'(dg_reg);
                    num1_next = {t1_reg, 1'b0} + NW'(dg_reg);
                    den_next  = DEN_W'(s_sq - (2*STRIDE_W)'(cfg_stride[0]));
                end
                state_next = B_FULL;
            end
            B_FULL:
            begin
                // dividend = diff * 2^16 + full, divisor = 2 * full
                rem0_next  = RW'(diff0_x) + RW'(full_v >> DENS_W);
                rem1_next  = RW'(diff1_x) + RW'(full_v >> DENS_W);
                lo_next    = DENS_W'(full_v);
                d2_next    = {full_v, 1'b0};
                q0_next    = '0;
                q1_next    = '0;
                cnt_next   = '0;
                state_next = B_DIV;
            end
            B_DIV:
            begin
                if (r2_0 >= RW'(d2_reg))
                begin
                    rem0_next = r2_0 - RW'(d2_reg);
                    q0_next   = {q0_reg[DENS_W-2:0], 1'b1};
                end
                else
                begin
                    rem0_next = r2_0;
                    q0_next   = {q0_reg[DENS_W-2:0], 1'b0};
                end
                if (r2_1 >= RW'(d2_reg))
                begin
                    rem1_next = r2_1 - RW'(d2_reg);
                    q1_next   = {q1_reg[DENS_W-2:0], 1'b1};
                end
                else
                begin
                    rem1_next = r2_1;
                    q1_next   = {q1_reg[DENS_W-2:0], 1'b0};
                end
                lo_next  = {lo_reg[DENS_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DC_W'(DENS_W - 1))
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_CLR;
            clr_addr_reg <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        dg_reg   <= dg_next;
        num0_reg <= num0_next;
        num1_reg <= num1_next;
        den_reg  <= den_next;
        d2_reg   <= d2_next;
        lo_reg   <= lo_next;
        rem0_reg <= rem0_next;
        rem1_reg <= rem1_next;
        q0_reg   <= q0_next;
        q1_reg   <= q1_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sum_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= sum_mem[item_in.col[CAW-1:0]];
        end
    end

endmodule

FILE: rtl/triangle_cell_density_averager_core.sv
// ----------------------------------------------------------------------------
// Triangle cell density averager core
// Raster pixels in, one pair of triangle densities out per finished cell.
// ----------------------------------------------------------------------------
// Pixels: one at a time; the front end holds full high until its bit-serial
//   split of the raster position into cell and offset (11 quotient steps) is
//   done and the item is queued, or dropped when it lies outside the grid.
// Path: an item passes the item queue to the column memory update; a cell's
//   result follows its last accepted pixel through the 16-step density
//   divider. Reset: registers return to stride 8, 640x480, box mode; the
//   column sum memory is then cleared with full held high.
module triangle_cell_density_averager_core
    import tcda_pkg::*;
#(
    parameter int MAX_STRIDE    = DEF_MAX_STRIDE,
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
    parameter int MAX_CELL_COLS = DEF_MAX_CELL_COLS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  push,
    output logic                  full,
    input  logic [PIX_W-1:0]      pixel_value,
    input  logic                  frame_start,
    input  logic                  pop,
    output logic                  empty,
    output logic [POS_W-1:0]      cell_row,
    output logic [POS_W-1:0]      cell_col,
    output logic [DENS_W-1:0]     upper_density,
    output logic [DENS_W-1:0]     lower_density,
    output logic                  last_of_frame
);

    // Register map, word index into paddr
    localparam logic [1:0] REG_STRIDE = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_BOX    = 2'd3;

    localparam int ITEM_W = $bits(cell_item_t);
    localparam int RES_W  = $bits(cell_result_t);

    logic [STRIDE_W-1:0] stride_reg, stride_next;
    logic [DIM_W-1:0]    width_reg, width_next;
    logic [DIM_W-1:0]    height_reg, height_next;
    logic                box_reg, box_next;
    logic                cfg_wr;
    logic [1:0]          cfg_idx;
    logic [STRIDE_W-1:0] wr_stride;
    logic [DIM_W-1:0]    wr_dim;

    cell_item_t          fe_item;
    logic                fe_push;
    logic                iq_full;
    logic [ITEM_W-1:0]   iq_rdata;
    logic                iq_empty;
    logic                be_pop;
    logic                clearing;
    cell_result_t        be_res;
    logic                be_push;
    logic                oq_full;
    logic [RES_W-1:0]    oq_rdata;
    cell_result_t        oq_res;

    // ------------------------------------------------------------------
    // Configuration port: zero wait states, values saturated into range
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[3:2];
    assign wr_stride = pwdata[STRIDE_W-1:0];
    assign wr_dim    = pwdata[DIM_W-1:0];

    always_comb
    begin
        stride_next = stride_reg;
        width_next  = width_reg;
        height_next = height_reg;
        box_next    = box_reg;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_STRIDE:
                begin
                    if (wr_stride < STRIDE_W'(2))
                    begin
                        stride_next = STRIDE_W'(2);
                    end
                    else if (int'(wr_stride) > MAX_STRIDE)
                    begin
                        stride_next = STRIDE_W'(MAX_STRIDE);
                    end
                    else
                    begin
                        stride_next = wr_stride;
                    end
                end
                REG_WIDTH:
                begin
                    if (wr_dim < DIM_W'(2))
                    begin
                        width_next = DIM_W'(2);
                    end
                    else if (int'(wr_dim) > MAX_WIDTH)
                    begin
                        width_next = DIM_W'(MAX_WIDTH);
                    end
                    else
                    begin
                        width_next = wr_dim;
                    end
                end
                REG_HEIGHT:
                begin
                    if (wr_dim < DIM_W'(2))
                    begin
                        height_next = DIM_W'(2);
                    end
                    else if (int'(wr_dim) > MAX_HEIGHT)
                    begin
                        height_next = DIM_W'(MAX_HEIGHT);
                    end
                    else
                    begin
                        height_next = wr_dim;
                    end
                end
                REG_BOX:
                begin
                    box_next = pwdata[0];
                end
                default:
                begin
                    box_next = box_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_STRIDE: prdata = CFG_DATA_W'(stride_reg);
            REG_WIDTH:  prdata = CFG_DATA_W'(width_reg);
            REG_HEIGHT: prdata = CFG_DATA_W'(height_reg);
            REG_BOX:    prdata = CFG_DATA_W'(box_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= STRIDE_W'(8);
            width_reg  <= DIM_W'(640);
            height_reg <= DIM_W'(480);
            box_reg    <= 1'b1;
        end
        else
        begin
            stride_reg <= stride_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            box_reg    <= box_next;
        end
    end

    // ------------------------------------------------------------------
    // Front end: position tracking and triangle classification
    // ------------------------------------------------------------------
    tcda_front #(
        .MAX_CELL_COLS (MAX_CELL_COLS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_stride  (stride_reg),
        .cfg_width   (width_reg),
        .cfg_height  (height_reg),
        .clearing    (clearing),
        .push        (push),
        .full        (full),
        .pixel_value (pixel_value),
        .frame_start (frame_start),
        .item_out    (fe_item),
        .item_push   (fe_push),
        .item_full   (iq_full)
    );

    // Queue between classification and accumulation
    tcda_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fe_push),
        .wdata (fe_item),
        .full  (iq_full),
        .pop   (be_pop),
        .rdata (iq_rdata),
        .empty (iq_empty)
    );

    // ------------------------------------------------------------------
    // Back end: column sum memory and density divider
    // ------------------------------------------------------------------
    tcda_back #(
        .MAX_STRIDE    (MAX_STRIDE),
        .MAX_CELL_COLS (MAX_CELL_COLS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_stride (stride_reg),
        .cfg_box    (box_reg),
        .clearing   (clearing),
        .item_in    (cell_item_t'(iq_rdata)),
        .item_empty (iq_empty),
        .item_pop   (be_pop),
        .res_out    (be_res),
        .res_push   (be_push),
        .res_full   (oq_full)
    );

    // Result queue: hold finished cells while the consumer stalls
    tcda_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (be_push),
        .wdata (be_res),
        .full  (oq_full),
        .pop   (pop),
        .rdata (oq_rdata),
        .empty (empty)
    );

    assign oq_res        = cell_result_t'(oq_rdata);
    assign cell_row      = oq_res.row;
    assign cell_col      = oq_res.col;
    assign upper_density = oq_res.upper;
    assign lower_density = oq_res.lower;
    assign last_of_frame = oq_res.lof;

endmodule

FILE: rtl/tcda_checker.sv
// ----------------------------------------------------------------------------
// Triangle cell density averager port checker
// Watch the top level's queue ports for rule breaks over time.
// ----------------------------------------------------------------------------
`include "triangle_cell_density_averager_core_assert.svh"

module tcda_checker
    import tcda_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              push,
    input logic              full,
    input logic              pop,
    input logic              empty,
    input logic [POS_W-1:0]  cell_row,
    input logic [DENS_W-1:0] upper_density,
    input logic [DENS_W-1:0] lower_density
);

    // Front end works one pixel at a time: busy right after a transaction
    `TCDA_ASSERT_NEXT(a_busy_after_push, push && !full, full, "full low after accepted pixel")

    // Densities never exceed 1.0 in Q1.15
    `TCDA_ASSERT_NOW(a_density_range, !empty, (upper_density <= 16'd32768) && (lower_density <= 16'd32768), "density above 1.0")

    // A waiting result stays put until popped
    `TCDA_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(cell_row) && $stable(upper_density) && $stable(lower_density), "result changed while stalled")

endmodule

bind triangle_cell_density_averager_core tcda_checker u_checker (.*);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Triangle cell density averager testbench
// Streams raster pixels through the core under several cell and image
// settings and compares every finished cell with an in-bench prediction.
// ----------------------------------------------------------------------------
module testbench;
    import tcda_pkg::*;

    // Register map, one 32-bit word per register
    typedef enum int {
        REG_STRIDE = 0,
        REG_WIDTH  = 1,
        REG_HEIGHT = 2,
        REG_BOX    = 3
    } reg_index_t;

    // Pixel content patterns for a phase
    typedef enum int {
        PIX_RANDOM,
        PIX_WHITE,
        PIX_BLACK
    } pix_pattern_t;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             fs;
    } raster_pixel_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  push = 1'b0;
    logic                  full;
    logic [PIX_W-1:0]      pixel_value = '0;
    logic                  frame_start = 1'b0;
    logic                  pop = 1'b0;
    logic                  empty;
    logic [POS_W-1:0]      cell_row;
    logic [POS_W-1:0]      cell_col;
    logic [DENS_W-1:0]     upper_density;
    logic [DENS_W-1:0]     lower_density;
    logic                  last_of_frame;

    triangle_cell_density_averager_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .pixel_value   (pixel_value),
        .frame_start   (frame_start),
        .pop           (pop),
        .empty         (empty),
        .cell_row      (cell_row),
        .cell_col      (cell_col),
        .upper_density (upper_density),
        .lower_density (lower_density),
        .last_of_frame (last_of_frame)
    );

    always #5 clk = ~clk;

    // Pixels waiting to be pushed, and cells the core still owes us
    raster_pixel_t pending_pixels[$];
    cell_result_t  expected_cells[$];

    // Idle rates in percent, changed per phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;

    // Shadow of the configuration and of the per-column accumulators
    int  cfg_stride = 8;
    int  cfg_width = 640;
    int  cfg_height = 480;
    bit  cfg_box = 1'b1;
    int  tri0_acc[DEF_MAX_CELL_COLS];
    int  tri1_acc[DEF_MAX_CELL_COLS];
    int  diag_acc[DEF_MAX_CELL_COLS];
    int  pos_x = 0;
    int  pos_y = 0;

    initial
    begin
        for (int i = 0; i < DEF_MAX_CELL_COLS; i++)
        begin
            tri0_acc[i] = 0;
            tri1_acc[i] = 0;
            diag_acc[i] = 0;
        end
    end

    function automatic int clamp_range(int v, int lo, int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Q1.15 density of (den*255 - num) over den*255, rounded half up, floored at zero
    function automatic logic [DENS_W-1:0] q15_density(longint num, longint den);
        longint whole;
        longint diff;
        whole = 255 * den;
        diff = (num < whole) ? whole - num : 0;
        return DENS_W'((diff * 65536 + whole) / (2 * whole));
    endfunction

    // Advance the raster position by one accepted pixel; queue a cell if done
    function automatic void accumulate_pixel(logic [PIX_W-1:0] pix, logic fs);
        int s;
        int rows;
        int cols;
        int col;
        int row;
        int cx;
        int cy;
        int dpos;
        bit odd;
        longint den;
        cell_result_t done_cell;
        s = cfg_stride;
        rows = cfg_height / s;
        cols = cfg_width / s;
        if (cols > DEF_MAX_CELL_COLS)
            cols = DEF_MAX_CELL_COLS;
        if (fs)
        begin
            pos_x = 0;
            pos_y = 0;
        end
        if (pos_x >= cfg_width)
        begin
            pos_x = 0;
            pos_y++;
        end
        if (pos_y >= cfg_height)
            pos_y = 0;
        col = pos_x / s;
        row = pos_y / s;
        cx = pos_x % s;
        cy = pos_y % s;
        if (col < cols && row < rows)
        begin
            odd = ((row + col) & 1) != 0;
            dpos = odd ? (s - 1 - cy) : cy;
            if (cx == 0 && cy == 0)
            begin
                tri0_acc[col] = 0;
                tri1_acc[col] = 0;
                diag_acc[col] = 0;
            end
            if (cx == dpos)
                diag_acc[col] += pix;
            else if (odd ? (cx < dpos) : (cx > dpos))
                tri0_acc[col] += pix;
            else
                tri1_acc[col] += pix;
            if (cx == s - 1 && cy == s - 1)
            begin
                done_cell.row = POS_W'(row);
                done_cell.col = POS_W'(col);
                if (cfg_box)
                begin
                    done_cell.upper = q15_density(tri0_acc[col] + tri1_acc[col]
                                                  + diag_acc[col], s * s);
                    done_cell.lower = done_cell.upper;
                end
                else
                begin
                    den = s * (s - 1) + 2 * (s / 2);
                    done_cell.upper = q15_density(2 * tri0_acc[col] + diag_acc[col], den);
                    done_cell.lower = q15_density(2 * tri1_acc[col] + diag_acc[col], den);
                end
                done_cell.lof = (row == rows - 1 && col == cols - 1);
                expected_cells.push_back(done_cell);
            end
        end
        pos_x++;
        if (pos_x >= cfg_width)
        begin
            pos_x = 0;
            pos_y++;
            if (pos_y >= cfg_height)
                pos_y = 0;
        end
    endfunction

    // Driver: predict on each accepted pixel, then present the next one or idle
    always @(posedge clk)
    begin
        raster_pixel_t nxt;
        if (rst_n)
        begin
            if (push && !full)
                accumulate_pixel(pixel_value, frame_start);
            // Hold the current transaction while the core is full
            if (!push || !full)
            begin
                if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_pixels.pop_front();
                    push <= 1'b1;
                    pixel_value <= nxt.pix;
                    frame_start <= nxt.fs;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Monitor: check each popped cell against the oldest prediction
    always @(posedge clk)
    begin
        cell_result_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_cells.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected cell row %0d col %0d", cell_row, cell_col);
                end
                else
                begin
                    want = expected_cells.pop_front();
                    if (cell_row !== want.row || cell_col !== want.col
                        || upper_density !== want.upper || lower_density !== want.lower
                        || last_of_frame !== want.lof)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("cell mismatch: want r%0d c%0d u%0d l%0d lof%0d, got r%0d c%0d u%0d l%0d lof%0d",
                                     want.row, want.col, want.upper, want.lower, want.lof,
                                     cell_row, cell_col, upper_density, lower_density,
                                     last_of_frame);
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // APB write: setup cycle, then access cycle; shadow follows the clamp rules
    task automatic write_reg(reg_index_t idx, int unsigned value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(idx * 4);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_STRIDE: cfg_stride = clamp_range(value & 32'h1f, 2, DEF_MAX_STRIDE);
            REG_WIDTH:  cfg_width  = clamp_range(value & 32'h7ff, 2, DEF_MAX_WIDTH);
            REG_HEIGHT: cfg_height = clamp_range(value & 32'h7ff, 2, DEF_MAX_HEIGHT);
            REG_BOX:    cfg_box    = value[0];
            default: ;
        endcase
    endtask

    // Wait until the core has drained, plus its worst-case pipeline depth
    task automatic drain();
        while (pending_pixels.size() != 0 || push || expected_cells.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // One phase: configure, pick idle rates, queue raster pixels
    task automatic run_phase(int stride, int width, int height, bit box, int count,
                             pix_pattern_t pattern, bit fresh_frame, int idle_mode);
        int gx;
        int gy;
        raster_pixel_t p;
        drain();
        write_reg(REG_STRIDE, stride);
        write_reg(REG_WIDTH, width);
        write_reg(REG_HEIGHT, height);
        write_reg(REG_BOX, box);
        case (idle_mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
        endcase
        // Without a fresh frame the generator leaves the core's carried position untracked until a stray frame start
        gx = fresh_frame ? 0 : -1;
        gy = 0;
        for (int i = 0; i < count; i++)
        begin
            case (pattern)
                PIX_WHITE: p.pix = 8'hff;
                PIX_BLACK: p.pix = 8'h00;
                default:
                    case ($urandom_range(9))
                        0: p.pix = 8'h00;
                        1: p.pix = 8'hff;
                        default: p.pix = PIX_W'($urandom_range(255));
                    endcase
            endcase
            // Mark frame tops; sprinkle stray frame starts as noise
            p.fs = (gx == 0 && gy == 0) || ($urandom_range(99) < 2);
            if (p.fs)
            begin
                gx = 0;
                gy = 0;
            end
            pending_pixels.push_back(p);
            if (gx >= 0)
            begin
                gx++;
                if (gx >= cfg_width)
                begin
                    gx = 0;
                    gy = (gy + 1 >= cfg_height) ? 0 : gy + 1;
                end
            end
        end
    endtask

    initial
    begin
        int s;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: saturating writes, all-white and all-black cells, an odd stride
        write_reg(REG_STRIDE, 0);
        write_reg(REG_STRIDE, 31);
        write_reg(REG_WIDTH, 0);
        write_reg(REG_WIDTH, 2047);
        write_reg(REG_HEIGHT, 1);
        write_reg(REG_HEIGHT, 2047);
        run_phase(2, 4, 2, 1'b0, 8, PIX_WHITE, 1'b1, 0);
        run_phase(2, 4, 2, 1'b1, 8, PIX_BLACK, 1'b1, 0);
        run_phase(3, 3, 3, 1'b0, 9, PIX_WHITE, 1'b1, 0);
        // Wide line with no whole cell row: every pixel ignored
        run_phase(16, 1024, 2, 1'b1, 20, PIX_RANDOM, 1'b1, 0);

        // Random content on well-formed frames, across settings and idle modes
        for (int ph = 0; ph < 12; ph++)
        begin
            s = $urandom_range(2, 5);
            run_phase(s, s * $urandom_range(1, 5) + $urandom_range(0, s - 1),
                      s * $urandom_range(1, 4) + $urandom_range(0, s - 1),
                      $urandom_range(1), 80, PIX_RANDOM, ph % 3 != 2, ph);
        end
        // Largest stride and tallest image, with leftover position carried in
        run_phase(16, 16, 16, 1'b0, 260, PIX_RANDOM, 1'b0, 3);
        run_phase(2, 4, 1024, 1'b1, 120, PIX_RANDOM, 1'b1, 1);
        drain();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
